### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/coapdec_pkg.sv
// Types and constants of the CoAP option stream decoder.
`default_nettype none

package coapdec_pkg;

   localparam logic KindOption = 1'b0;
   localparam logic KindEnd    = 1'b1;

   localparam logic [2:0] StatusOk          = 3'd0;
   localparam logic [2:0] StatusResDelta    = 3'd1;
   localparam logic [2:0] StatusResLength   = 3'd2;
   localparam logic [2:0] StatusTruncated   = 3'd3;
   localparam logic [2:0] StatusNumOverflow = 3'd4;

   localparam logic [3:0] NibbleExtOne  = 4'd13;
   localparam logic [3:0] NibbleExtTwo  = 4'd14;
   localparam logic [3:0] NibbleReserved = 4'd15;

   localparam logic [16:0] ExtOneBias = 17'd13;
   localparam logic [16:0] ExtTwoBias = 17'd269;

   localparam logic [15:0] PositionMax = 16'hFFFF;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] opt_num;
      logic [16:0] option_delta;
      logic [16:0] option_length;
      logic [15:0] value_offset;
      logic [7:0]  option_count;
      logic [2:0]  status;
      logic        last_result;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/coap_option_stream_decoder_core.sv
// CoAP option stream decoder: option header parsing and result queue.
`default_nettype none
`include "assert_macros.svh"

// Takes the options byte string of a CoAP message on the req_ channel, one
// byte per transaction, with req_last_byte set on the final byte. Each option
// header (delta and length nibbles with their one- or two-byte extensions) is
// decoded, option numbers accumulate, and value bytes are skipped.
// The rsp_ channel returns one descriptor per option, an end summary after
// the final byte, or an error result; after an error the rest of the string
// gives nothing and the final byte re-arms the decoder.
// A result is registered and offered in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the receiver takes the results; a byte
// that yields two results (a header's last byte that is also the string's last
// byte) holds the input back, since the two-entry result queue must drain to
// one entry before the next byte is taken.
// A stalled receiver holds the queue head unchanged; the input stalls only
// while the queue cannot take the results of another byte.
// Synchronous reset empties the queue and returns the parser to the state
// of awaiting the first header byte.
module coap_option_stream_decoder_core #(
   parameter int MAX_OPTIONS = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_result_kind,
   output logic [15:0]      rsp_opt_num,
   output logic [16:0]      rsp_option_delta,
   output logic [16:0]      rsp_option_length,
   output logic [15:0]      rsp_value_offset,
   output logic [7:0]       rsp_option_count,
   output logic [2:0]       rsp_status,
   output logic             rsp_last_result
);
   import coapdec_pkg::*;

   localparam logic [2:0] PhHdr   = 3'd0;
   localparam logic [2:0] PhDx1   = 3'd1;
   localparam logic [2:0] PhDx2h  = 3'd2;
   localparam logic [2:0] PhDx2l  = 3'd3;
   localparam logic [2:0] PhLx1   = 3'd4;
   localparam logic [2:0] PhLx2h  = 3'd5;
   localparam logic [2:0] PhLx2l  = 3'd6;
   localparam logic [2:0] PhValue = 3'd7;

   localparam logic [7:0] MaxCount = 8'(MAX_OPTIONS);

   // Parser state.
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  len_nib_ff, len_nib_in;
   logic [7:0]  ext_high_ff, ext_high_in;
   logic [16:0] pend_delta_ff, pend_delta_in;
   logic [15:0] run_num_ff, run_num_in;
   logic [16:0] left_ff, left_in;
   logic [15:0] pos_ff;
   logic [7:0]  seen_ff, seen_in;
   logic        err_ff, err_in;

   // Result queue.
   result_type  slot0_ff, slot0_in;
   result_type  slot1_ff, slot1_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic        req_acc, rsp_pop;
   logic [15:0] pos_next;
   logic [3:0]  len_nib_eff;
   logic [17:0] num_sum;
   logic        do_after, do_complete, do_fail, do_desc, do_end;
   logic [2:0]  fail_status;
   logic [1:0]  num_results;
   result_type  desc_rec, kind1_rec, rec0, rec1;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_pop   = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_pop));
   assign req_acc   = req_valid && !req_stall;

   assign pos_next    = (pos_ff < PositionMax) ? pos_ff + 16'd1 : pos_ff;
   assign len_nib_eff = (phase_ff == PhHdr) ? req_data_byte[3:0] : len_nib_ff;

   // Decode of one byte: phase update, header completion and error checks.
   always_comb begin
      phase_in      = phase_ff;
      len_nib_in    = len_nib_ff;
      ext_high_in   = ext_high_ff;
      pend_delta_in = pend_delta_ff;
      run_num_in    = run_num_ff;
      left_in       = left_ff;
      seen_in       = seen_ff;
      err_in        = err_ff;
      do_after      = 1'b0;
      do_complete   = 1'b0;
      do_fail       = 1'b0;
      do_desc       = 1'b0;
      fail_status   = StatusOk;
      num_sum       = 18'd0;

      case (phase_ff)
         PhHdr: begin
            len_nib_in = req_data_byte[3:0];
            if (req_data_byte[7:4] == NibbleReserved) begin
               do_fail     = 1'b1;
               fail_status = StatusResDelta;
            end else if (req_data_byte[3:0] == NibbleReserved) begin
               do_fail     = 1'b1;
               fail_status = StatusResLength;
            end else if (req_data_byte[7:4] == NibbleExtOne) begin
               phase_in = PhDx1;
            end else if (req_data_byte[7:4] == NibbleExtTwo) begin
               phase_in = PhDx2h;
            end else begin
               pend_delta_in = {13'd0, req_data_byte[7:4]};
               do_after      = 1'b1;
            end
         end
         PhDx1: begin
            pend_delta_in = {9'd0, req_data_byte} + ExtOneBias;
            do_after      = 1'b1;
         end
         PhDx2h: begin
            ext_high_in = req_data_byte;
            phase_in    = PhDx2l;
         end
         PhDx2l: begin
            pend_delta_in = {1'b0, ext_high_ff, req_data_byte} + ExtTwoBias;
            do_after      = 1'b1;
         end
         PhLx1: begin
            left_in     = {9'd0, req_data_byte} + ExtOneBias;
            do_complete = 1'b1;
         end
         PhLx2h: begin
            ext_high_in = req_data_byte;
            phase_in    = PhLx2l;
         end
         PhLx2l: begin
            left_in     = {1'b0, ext_high_ff, req_data_byte} + ExtTwoBias;
            do_complete = 1'b1;
         end
         default: begin
            if (left_ff > 17'd1) begin
               left_in = left_ff - 17'd1;
            end else begin
               left_in  = 17'd0;
               phase_in = PhHdr;
            end
         end
      endcase

      if (do_after) begin
         if (len_nib_eff == NibbleExtOne) begin
            phase_in = PhLx1;
         end else if (len_nib_eff == NibbleExtTwo) begin
            phase_in = PhLx2h;
         end else begin
            left_in     = {13'd0, len_nib_eff};
            do_complete = 1'b1;
         end
      end

      if (do_complete) begin
         num_sum = {2'd0, run_num_ff} + {1'b0, pend_delta_in};
         if (num_sum[17:16] != 2'd0) begin
            do_fail     = 1'b1;
            fail_status = StatusNumOverflow;
         end else begin
            do_desc    = 1'b1;
            run_num_in = num_sum[15:0];
            if (seen_ff < MaxCount) begin
               seen_in = seen_ff + 8'd1;
            end
            phase_in = (left_in != 17'd0) ? PhValue : PhHdr;
         end
      end

      if (do_fail) begin
         err_in = 1'b1;
      end
   end

   assign do_end = req_last_byte && !do_fail;

   always_comb begin
      desc_rec.result_kind   = KindOption;
      desc_rec.opt_num       = run_num_in;
      desc_rec.option_delta  = pend_delta_in;
      desc_rec.option_length = left_in;
      desc_rec.value_offset  = pos_next;
      desc_rec.option_count  = seen_in;
      desc_rec.status        = StatusOk;
      desc_rec.last_result   = !req_last_byte;

      // Error and end summary share one layout; only the status differs.
      kind1_rec.result_kind   = KindEnd;
      kind1_rec.opt_num       = run_num_in;
      kind1_rec.option_delta  = 17'd0;
      kind1_rec.option_length = 17'd0;
      kind1_rec.value_offset  = pos_next;
      kind1_rec.option_count  = seen_in;
      if (do_fail) begin
         kind1_rec.status = fail_status;
      end else if (phase_in == PhHdr) begin
         kind1_rec.status = StatusOk;
      end else begin
         kind1_rec.status = StatusTruncated;
      end
      kind1_rec.last_result = 1'b1;

      rec0 = do_desc ? desc_rec : kind1_rec;
      rec1 = kind1_rec;

      if (err_ff) begin
         num_results = 2'd0;
      end else if (do_desc && do_end) begin
         num_results = 2'd2;
      end else if (do_desc || do_fail || do_end) begin
         num_results = 2'd1;
      end else begin
         num_results = 2'd0;
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (req_acc) begin
         cnt_in   = num_results;
         slot0_in = rec0;
         slot1_in = rec1;
      end else if (rsp_pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (req_acc && req_last_byte)) begin
         phase_ff      <= PhHdr;
         len_nib_ff    <= 4'd0;
         ext_high_ff   <= 8'd0;
         pend_delta_ff <= 17'd0;
         run_num_ff    <= 16'd0;
         left_ff       <= 17'd0;
         pos_ff        <= 16'd0;
         seen_ff       <= 8'd0;
         err_ff        <= 1'b0;
      end else if (req_acc && !err_ff) begin
         phase_ff      <= phase_in;
         len_nib_ff    <= len_nib_in;
         ext_high_ff   <= ext_high_in;
         pend_delta_ff <= pend_delta_in;
         run_num_ff    <= run_num_in;
         left_ff       <= left_in;
         pos_ff        <= pos_next;
         seen_ff       <= seen_in;
         err_ff        <= err_in;
      end
   end

   assign rsp_result_kind   = slot0_ff.result_kind;
   assign rsp_opt_num       = slot0_ff.opt_num;
   assign rsp_option_delta  = slot0_ff.option_delta;
   assign rsp_option_length = slot0_ff.option_length;
   assign rsp_value_offset  = slot0_ff.value_offset;
   assign rsp_option_count  = slot0_ff.option_count;
   assign rsp_status        = slot0_ff.status;
   assign rsp_last_result   = slot0_ff.last_result;

   `ASSERT_IMP(a_accept_needs_room, clock, reset, req_acc,
      (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_pop))
   `ASSERT_IMP(a_no_result_after_error, clock, reset, req_acc && err_ff,
      num_results == 2'd0)
   `ASSERT_IMP(a_status_only_on_end, clock, reset, rsp_valid && (rsp_status != StatusOk),
      rsp_result_kind == KindEnd)
   `ASSERT_IMP(a_pair_head_in_full_queue, clock, reset, rsp_valid && !rsp_last_result,
      cnt_ff == 2'd2)

endmodule

`default_nettype wire
